// ===== rtl/ipt_pkg.sv =====
package ipt_pkg;

	localparam int PH_W   = 40;
	localparam int FREQ_W = 32;
	localparam int PER_W  = 32;
	localparam int PROD_W = 64;
	localparam int EXT_W  = PH_W + 2;

	localparam logic [PER_W-1:0] PERIOD_RESET = 32'd89478;

	localparam logic signed [EXT_W-1:0] ONE_CYCLE = 42'sh0_0001_0000_0000;
	localparam logic signed [EXT_W-1:0] S40_MAX   = 42'sh0_7F_FFFF_FFFF;
	localparam logic signed [EXT_W-1:0] S40_MIN   = 42'sh380_0000_0000;

	localparam logic signed [PROD_W-1:0] STEP_MAX = 64'sh0000_007F_FFFF_FFFF;
	localparam logic signed [PROD_W-1:0] STEP_MIN = 64'shFFFF_FF80_0000_0000;

	typedef logic signed [PH_W-1:0] phase_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		phase_t                   offset;
		logic                     restart;
	} stage_t;

	typedef struct packed {
		logic   hit;
		phase_t phase;
	} wrap_t;

	function automatic logic signed [EXT_W-1:0] ext(input phase_t p);
		return {{2{p[PH_W-1]}}, p};
	endfunction

	function automatic phase_t sat40(input logic signed [EXT_W-1:0] x);
		phase_t r;
		if (x > S40_MAX) begin
			r = S40_MAX[PH_W-1:0];
		end else if (x < S40_MIN) begin
			r = S40_MIN[PH_W-1:0];
		end else begin
			r = x[PH_W-1:0];
		end
		return r;
	endfunction

	function automatic phase_t sat_step(input logic signed [PROD_W-1:0] prod);
		logic signed [PROD_W-1:0] q;
		phase_t r;
		q = prod >>> 8;
		if (q > STEP_MAX) begin
			r = STEP_MAX[PH_W-1:0];
		end else if (q < STEP_MIN) begin
			r = STEP_MIN[PH_W-1:0];
		end else begin
			r = q[PH_W-1:0];
		end
		return r;
	endfunction

	function automatic wrap_t wrap_test(input logic neg, input phase_t p);
		logic signed [EXT_W-1:0] x;
		logic signed [EXT_W-1:0] y;
		logic signed [EXT_W-1:0] t;
		wrap_t r;
		x = ext(p);
		y = x;
		t = '0;
		r.hit = 1'b0;
		r.phase = p;
		if (neg) begin
			if (x <= 42'sd0) begin
				y = x + ONE_CYCLE;
				if (y <= 42'sd0) begin
					t = -y;
					y = -$signed({10'd0, t[31:0]});
				end
				r.hit = 1'b1;
				r.phase = y[PH_W-1:0];
			end
		end else begin
			if (x >= ONE_CYCLE) begin
				y = x - ONE_CYCLE;
				if (y >= ONE_CYCLE) begin
					y = $signed({10'd0, y[31:0]});
				end
				r.hit = 1'b1;
				r.phase = y[PH_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/impulse_phasor_trigger.sv =====
// Impulse oscillator with phase modulation: every request carries a frequency (signed Q24.8 Hz),
// a phase offset (signed Q8.32 cycles) and a restart flag, and yields one impulse bit that is
// high when the phase wrapped on that sample. One request is taken per cycle while req_stall is low,
// and its result passes three registered stages: the input register, the frequency times
// sample-period multiply, and the phase update, whose wrap, offset and increment logic is
// combinational and feeds the phase state register. The sample period is a 32-bit Q0.32
// register, reset to 89478; write it only while idle, as the block does not enforce this.
module impulse_phasor_trigger (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic signed [31:0] frequency,
	input  logic signed [39:0] phase_offset,
	input  logic               restart,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               impulse,
	input  logic               sample_period_we,
	input  logic [31:0]        sample_period
);
	import ipt_pkg::*;

	logic   req_ready;
	logic   s2_valid;
	logic   s2_ready;
	stage_t s2_data;

	assign req_stall = !req_ready;

	ipt_mult u_mult (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.frequency    (frequency),
		.phase_offset (phase_offset),
		.restart      (restart),
		.period_we    (sample_period_we),
		.period_wdata (sample_period),
		.s2_valid     (s2_valid),
		.s2_ready     (s2_ready),
		.s2_data      (s2_data)
	);

	ipt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2_valid  (s2_valid),
		.s2_ready  (s2_ready),
		.s2_data   (s2_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.impulse   (impulse)
	);

endmodule

// ===== rtl/ipt_mult.sv =====
module ipt_mult (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic signed [31:0]          frequency,
	input  logic signed [39:0]          phase_offset,
	input  logic                        restart,
	input  logic                        period_we,
	input  logic [31:0]                 period_wdata,
	output logic                        s2_valid,
	input  logic                        s2_ready,
	output ipt_pkg::stage_t             s2_data
);
	import ipt_pkg::*;

	logic [PER_W-1:0]          sample_period_q;
	logic                      valid_s1;
	logic signed [FREQ_W-1:0]  freq_s1;
	phase_t                    offset_s1;
	logic                      restart_s1;
	logic                      valid_s2;
	stage_t                    data_s2;
	logic signed [PROD_W:0]    prod_full;
	logic                      s1_ready;

	assign s1_ready  = !valid_s1 || s2_ready;
	assign req_ready = s1_ready;
	assign prod_full = $signed(freq_s1) * $signed({1'b0, sample_period_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= PERIOD_RESET;
		end else if (period_we) begin
			sample_period_q <= period_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= req_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && req_valid) begin
			freq_s1    <= frequency;
			offset_s1  <= phase_offset;
			restart_s1 <= restart;
		end
		if (s2_ready && valid_s1) begin
			data_s2.prod    <= prod_full[PROD_W-1:0];
			data_s2.offset  <= offset_s1;
			data_s2.restart <= restart_s1;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_data  = data_s2;

endmodule

// ===== rtl/ipt_core.sv =====
module ipt_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s2_valid,
	output logic            s2_ready,
	input  ipt_pkg::stage_t s2_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output logic            impulse
);
	import ipt_pkg::*;

	phase_t phase_acc_q;
	phase_t last_offset_q;
	phase_t phase_step_q;
	logic   out_valid_q;
	logic   impulse_q;

	phase_t step;
	phase_t start_phase;
	wrap_t  start_wrap;
	wrap_t  first_wrap;
	wrap_t  second_wrap;
	phase_t mod_phase;
	phase_t next_phase;
	logic   out_ready;
	logic   advance;

	assign out_ready = !out_valid_q || !rsp_stall;
	assign s2_ready  = out_ready;
	assign advance   = s2_valid && out_ready;

	always_comb begin
		step = sat_step(s2_data.prod);
		start_phase = {8'd0, s2_data.offset[31:0]};
		if (s2_data.offset[31:0] == 32'd0 && !step[PH_W-1]) begin
			start_phase = ONE_CYCLE[PH_W-1:0];
		end
		start_wrap  = wrap_test(step[PH_W-1], start_phase);
		first_wrap  = wrap_test(phase_step_q[PH_W-1], phase_acc_q);
		mod_phase   = sat40(ext(first_wrap.phase) + (ext(s2_data.offset) - ext(last_offset_q)));
		second_wrap = wrap_test(phase_step_q[PH_W-1], mod_phase);
		next_phase  = sat40(ext(second_wrap.phase) + ext(step));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q   <= '0;
			last_offset_q <= '0;
			phase_step_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= s2_valid;
			end
			if (advance) begin
				last_offset_q <= s2_data.offset;
				phase_step_q  <= step;
				phase_acc_q   <= s2_data.restart ? start_phase : next_phase;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			impulse_q <= s2_data.restart ? start_wrap.hit : first_wrap.hit;
		end
	end

	assign rsp_valid = out_valid_q;
	assign impulse   = impulse_q;

endmodule

// ===== rtl/ipt_checker.sv =====
module ipt_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input logic impulse
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(impulse))
		else $error("stalled response changed");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with empty output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
		else $error("response missing after request");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("response valid during reset");

endmodule

bind impulse_phasor_trigger ipt_checker u_ipt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.impulse   (impulse)
);
